[rtl/core/b2d_pkg.sv]
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package b2d_pkg;

    localparam int DIGIT_CHAR_W = 6;
    localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO = 6'd48;   // '0' masked to 6 bits
    localparam logic [DIGIT_CHAR_W-1:0] ASCII_NINE = 6'd57;   // '9' masked to 6 bits

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic dec_idx;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic digit_zero;
        logic idx_zero;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/binary_to_decimal_ascii_top.sv]
// Top level of the binary to decimal ASCII converter.
// Depends on b2d_pkg, b2d_ctrl and b2d_datapath.
//
// Converts one unsigned value (low VALUE_BITS bits of s_value) to decimal
// ASCII digits, most significant first, leading zeros dropped; zero gives a
// single '0'. Each digit is one m_ transfer, m_last_digit marks the units digit.
// One value is handled at a time: s_ready is high only while idle. An item
// goes through a load, VALUE_BITS double-dabble shift steps, a skip step per
// suppressed leading zero (up to D-1, D = 10 for 32 bits) plus a step that
// settles on the first digit, and then one emitted digit per m_ transfer;
// while m_ready is low the current digit is held.
`default_nettype none

module binary_to_decimal_ascii_top #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [31:0]                       s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [b2d_pkg::DIGIT_CHAR_W-1:0]       m_digit_char,
    output logic                                   m_last_digit
);

    b2d_pkg::ctrl_cmd_t  cmd;
    b2d_pkg::dp_status_t status;

    b2d_ctrl #(
        .VALUE_BITS(VALUE_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    b2d_datapath #(
        .VALUE_BITS(VALUE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .value      (s_value),
        .cmd        (cmd),
        .status     (status),
        .digit_char (m_digit_char)
    );

    assign m_last_digit = status.idx_zero;

    // never accepting and offering a result at the same time
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("s_ready and m_valid both high");

    // emitted characters are decimal digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_char >= b2d_pkg::ASCII_ZERO && m_digit_char <= b2d_pkg::ASCII_NINE))
        else $error("digit out of range");

    // an accepted input makes the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("still ready after input transfer");

    // transfer of the last digit returns the block to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_digit) |=> (s_ready && !m_valid))
        else $error("not idle after last digit");

endmodule

`default_nettype wire

[rtl/core/b2d_datapath.sv]
// Datapath: double-dabble shift/add-3 register and digit select for output.
// Depends on b2d_pkg for command/status structs and ASCII constants.
`default_nettype none

module b2d_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic [31:0]                       value,
    input  wire b2d_pkg::ctrl_cmd_t                cmd,
    output b2d_pkg::dp_status_t                    status,
    output logic [b2d_pkg::DIGIT_CHAR_W-1:0]       digit_char
);

    // enough decimal digits for 2^VALUE_BITS - 1 (log10(2) ~ 0.30103)
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IDX_W  = $clog2(DIGITS);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [4*DIGITS-1:0]   bcd_reg, bcd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [4*DIGITS-1:0]   adj;
    logic [3:0]            digits [DIGITS];
    logic [3:0]            cur_digit;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            digits[i] = bcd_reg[4*i +: 4];
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? (bcd_reg[4*i +: 4] + 4'd3)
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        idx_next = idx_reg;
        if (cmd.load) begin
            bin_next = value[VALUE_BITS-1:0];
            bcd_next = '0;
            idx_next = IDX_W'(DIGITS - 1);
        end else if (cmd.shift) begin
            bcd_next = {adj[4*DIGITS-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
        end else if (cmd.dec_idx) begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        idx_reg <= idx_next;
    end

    assign cur_digit         = digits[idx_reg];
    assign status.digit_zero = (cur_digit == 4'd0);
    assign status.idx_zero   = (idx_reg == '0);
    assign digit_char        = b2d_pkg::ASCII_ZERO + {2'b00, cur_digit};

endmodule

`default_nettype wire

[rtl/core/b2d_ctrl.sv]
// Controller FSM: sequences load, VALUE_BITS shift steps, leading-zero skip
// and digit emission. Depends on b2d_pkg for the state enum and structs.
`default_nettype none

module b2d_ctrl #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire b2d_pkg::dp_status_t status,
    output b2d_pkg::ctrl_cmd_t       cmd
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    b2d_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= b2d_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            b2d_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(VALUE_BITS - 1);
                    state_next = b2d_pkg::ST_CONV;
                end
            end
            b2d_pkg::ST_CONV: begin
                cmd.shift = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = b2d_pkg::ST_SKIP;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            b2d_pkg::ST_SKIP: begin
                // drop leading zeros, but always keep the units digit
                if (status.digit_zero && !status.idx_zero) begin
                    cmd.dec_idx = 1'b1;
                end else begin
                    state_next = b2d_pkg::ST_EMIT;
                end
            end
            b2d_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.idx_zero) begin
                        state_next = b2d_pkg::ST_IDLE;
                    end else begin
                        cmd.dec_idx = 1'b1;
                    end
                end
            end
            default: begin
                state_next = b2d_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
